// ===== rtl/bnr_pkg.sv =====
// Shared types and constants for the batch-norm/ReLU channel block.
`default_nettype none
package bnr_pkg;

    localparam int MAX_SPATIAL  = 64;
    localparam int SPATIAL_W    = $clog2(MAX_SPATIAL);
    localparam int FILL_W       = SPATIAL_W + 1;
    localparam int MAX_CHANNELS = 256;
    localparam int CH_W         = $clog2(MAX_CHANNELS);
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int DIV_NUM_W    = 40;
    localparam int DIV_DEN_W    = 25;
    localparam int SQRT_W       = 50;
    localparam int SQRT_STEPS   = 25;
    localparam int CFG_IDX_W    = 2;

    localparam logic [31:0] VAR_ONE      = 32'h0001_0000;
    localparam logic [15:0] MOMENTUM_RST = 16'd6554;
    localparam logic [15:0] EPSILON_RST  = 16'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_TRAINING = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELU     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOMENTUM = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EPSILON  = 2'd3;

    typedef enum logic {
        KIND_SAMPLE = 1'b0,
        KIND_LOAD   = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [CH_W-1:0]    channel;
        logic signed [15:0] sample;
        logic               last;
        logic signed [15:0] scale;
        logic signed [15:0] shift;
        logic signed [15:0] load_mean;
        logic [31:0]        load_var;
    } t_cmd;

    typedef struct packed {
        logic        training_mode;
        logic        relu_enable;
        logic [15:0] momentum;
        logic [15:0] epsilon;
    } t_cfg;

    typedef enum logic [4:0] {
        ST_IDLE, ST_STAT, ST_MDIV, ST_VRD, ST_VSQ, ST_VACC, ST_VSTART, ST_VDIV,
        ST_UPD1, ST_UPD2, ST_SQI, ST_SQ, ST_INV, ST_IDIV, ST_ORD, ST_OM1,
        ST_OM2, ST_OFIN
    } t_back_state;

endpackage
`default_nettype wire

// ===== rtl/bnr_front.sv =====
// Front end: take input items, classify them and hand commands to the queue.
`default_nettype none
module bnr_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic                        i_req_type,
    input  wire logic [bnr_pkg::CH_W-1:0]    i_channel,
    input  wire logic signed [15:0]          i_sample_value,
    input  wire logic                        i_last_in_channel,
    input  wire logic signed [15:0]          i_scale,
    input  wire logic signed [15:0]          i_shift,
    input  wire logic signed [15:0]          i_load_mean,
    input  wire logic [31:0]                 i_load_variance,
    output logic                             o_push,
    output bnr_pkg::t_cmd                    o_cmd,
    input  wire logic                        i_full
);
    import bnr_pkg::*;

    logic r_full;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic accept;

    assign o_stall = r_full && i_full;
    assign accept  = i_valid && !o_stall;
    assign o_push  = r_full && !i_full;
    assign o_cmd   = r_cmd;

    always_comb begin
        n_cmd.kind      = i_req_type ? KIND_LOAD : KIND_SAMPLE;
        n_cmd.channel   = i_channel;
        n_cmd.sample    = i_sample_value;
        // a load never ends a plane
        n_cmd.last      = i_last_in_channel && !i_req_type;
        n_cmd.scale     = i_scale;
        n_cmd.shift     = i_shift;
        n_cmd.load_mean = i_load_mean;
        n_cmd.load_var  = i_load_variance;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (accept) begin
            r_full <= 1'b1;
        end else if (o_push) begin
            r_full <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/bnr_queue.sv =====
// Short command queue between front end and back end.
`default_nettype none
module bnr_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire bnr_pkg::t_cmd i_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output bnr_pkg::t_cmd      o_data,
    output logic               o_empty
);
    import bnr_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_count;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) i_push |-> !o_full)
        else $error("push into full queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) i_pop |-> !o_empty)
        else $error("pop from empty queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QPTR_W+1)'(QUEUE_DEPTH))
        else $error("queue count overflow");

endmodule
`default_nettype wire

// ===== rtl/bnr_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module bnr_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [bnr_pkg::DIV_NUM_W-1:0] i_num,
    input  wire logic [bnr_pkg::DIV_DEN_W-1:0] i_den,
    output logic                               o_done,
    output logic [bnr_pkg::DIV_NUM_W-1:0]      o_quot
);
    import bnr_pkg::*;

    localparam int CNT_W = $clog2(DIV_NUM_W);

    logic                 r_busy;
    logic [CNT_W-1:0]     r_cnt;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_NUM_W-1:0] r_q;
    logic                 r_done;
    logic [DIV_DEN_W:0]   rem_sh;
    logic                 ge;
    logic [DIV_DEN_W:0]   rem_sub;

    assign rem_sh  = {r_rem, r_q[DIV_NUM_W-1]};
    assign ge      = rem_sh >= {1'b0, r_den};
    assign rem_sub = rem_sh - {1'b0, r_den};
    assign o_done  = r_done;
    assign o_quot  = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_NUM_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_q   <= i_num;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
            r_q   <= {r_q[DIV_NUM_W-2:0], ge};
        end
    end

endmodule
`default_nettype wire

// ===== rtl/bnr_back.sv =====
// Back end: sample buffer, statistics, running tables and per-sample output.
`default_nettype none
module bnr_back (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire bnr_pkg::t_cfg                    i_cfg,
    input  wire bnr_pkg::t_cmd                    i_cmd,
    input  wire logic                             i_empty,
    output logic                                  o_pop,
    output logic                                  o_valid,
    input  wire logic                             i_stall,
    output logic signed [15:0]                    o_out_value,
    output logic signed [15:0]                    o_pre_activation,
    output logic [bnr_pkg::SPATIAL_W-1:0]         o_element_index,
    output logic                                  o_last_of_run,
    output logic signed [15:0]                    o_channel_mean,
    output logic [31:0]                           o_channel_variance
);
    import bnr_pkg::*;

    t_back_state r_state;
    t_back_state n_state;

    // sample buffer
    logic signed [15:0]   r_buf [MAX_SPATIAL];
    logic signed [15:0]   r_rdata;
    logic                 buf_we;

    // running statistics tables
    logic signed [15:0]      r_tmean [MAX_CHANNELS];
    logic [31:0]             r_tvar  [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0] r_tvalid;
    logic signed [15:0]      r_tm_rd;
    logic [31:0]             r_tv_rd;
    logic                    r_tvalid_rd;
    logic                    tab_we;
    logic [CH_W-1:0]         tab_wa;
    logic [CH_W-1:0]         tab_ra;
    logic signed [15:0]      tab_wmean;
    logic [31:0]             tab_wvar;

    logic [FILL_W-1:0]    r_fill;
    logic signed [23:0]   r_sum;
    logic [CH_W-1:0]      r_ch;
    logic signed [15:0]   r_gamma;
    logic signed [15:0]   r_beta;
    logic signed [15:0]   r_mean;
    logic [31:0]          r_var;
    logic signed [15:0]   r_old_mean;
    logic [31:0]          r_old_var;
    logic [SPATIAL_W-1:0] r_idx;
    logic [38:0]          r_acc;
    logic [31:0]          r_sq;
    logic [DIV_DEN_W-1:0] r_inv;
    logic signed [32:0]   r_gd;
    logic signed [58:0]   r_prod;
    logic signed [34:0]   r_p1;
    logic signed [34:0]   r_p2;
    logic [48:0]          r_p3;
    logic [47:0]          r_p4;
    logic [SQRT_W-1:0]    r_sv;
    logic [SQRT_W-1:0]    r_sres;
    logic [SQRT_W-1:0]    r_sbit;
    logic [4:0]           r_scnt;

    logic                 r_ovalid;

    logic                 div_start;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic                 div_done;
    logic [DIV_NUM_W-1:0] div_quot;

    logic                 is_last_idx;
    logic                 out_load;
    logic signed [16:0]   diff;
    logic signed [33:0]   diff_sq;
    logic signed [25:0]   mean_t;
    logic [16:0]          one_minus_mom;
    logic signed [35:0]   am;
    logic [49:0]          av;
    logic [32:0]          s_sum;
    logic [SQRT_W-1:0]    sq_try;
    logic                 sq_ge;
    logic signed [58:0]   y_rnd;
    logic signed [31:0]   y_sum;
    logic signed [15:0]   y_sat;
    logic signed [15:0]   old_mean;
    logic [31:0]          old_var;

    assign is_last_idx   = ({1'b0, r_idx} == (r_fill - 1'b1));
    assign out_load      = (r_state == ST_OFIN) && (!r_ovalid || !i_stall);
    assign diff          = $signed({r_rdata[15], r_rdata}) - $signed({r_mean[15], r_mean});
    assign diff_sq       = diff * diff;
    assign mean_t        = $signed({r_sum[23], r_sum, 1'b0})
                         + $signed({19'b0, r_fill})
                         + $signed({2'b0, r_fill, 17'b0});
    assign one_minus_mom = 17'h1_0000 - {1'b0, i_cfg.momentum};
    assign am            = 36'(r_p1) + 36'(r_p2) + 36'sd32768;
    assign av            = 50'(r_p3) + 50'(r_p4) + 50'd32768;
    assign s_sum         = {1'b0, r_var} + {17'b0, i_cfg.epsilon};
    assign sq_try        = r_sres + r_sbit;
    assign sq_ge         = r_sv >= sq_try;
    assign y_rnd         = (r_prod + 59'sd134217728) >>> 28;
    assign y_sum         = y_rnd[31:0] + 32'(r_beta);
    assign old_mean      = r_tvalid_rd ? r_tm_rd : 16'sd0;
    assign old_var       = r_tvalid_rd ? r_tv_rd : VAR_ONE;

    always_comb begin
        if (y_sum > 32'sd32767) begin
            y_sat = 16'sh7FFF;
        end else if (y_sum < -32'sd32768) begin
            y_sat = -16'sh8000;
        end else begin
            y_sat = y_sum[15:0];
        end
    end

    bnr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // next state and strobes
    always_comb begin
        n_state   = r_state;
        o_pop     = 1'b0;
        buf_we    = 1'b0;
        tab_we    = 1'b0;
        tab_wa    = r_ch;
        tab_wmean = am[31:16];
        tab_wvar  = av[47:16];
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    if (i_cmd.kind == KIND_LOAD) begin
                        tab_we    = 1'b1;
                        tab_wa    = i_cmd.channel;
                        tab_wmean = i_cmd.load_mean;
                        tab_wvar  = i_cmd.load_var;
                    end else begin
                        buf_we = (r_fill < FILL_W'(MAX_SPATIAL));
                        if (i_cmd.last) begin
                            n_state = ST_STAT;
                        end
                    end
                end
            end
            ST_STAT: begin
                if (i_cfg.training_mode) begin
                    div_start = 1'b1;
                    div_num   = {16'b0, mean_t[23:0]};
                    div_den   = {17'b0, r_fill, 1'b0};
                    n_state   = ST_MDIV;
                end else begin
                    n_state = ST_SQI;
                end
            end
            ST_MDIV: begin
                if (div_done) begin
                    n_state = ST_VRD;
                end
            end
            ST_VRD:  n_state = ST_VSQ;
            ST_VSQ:  n_state = ST_VACC;
            ST_VACC: n_state = is_last_idx ? ST_VSTART : ST_VRD;
            ST_VSTART: begin
                div_start = 1'b1;
                div_num   = {r_acc, 1'b0} + 40'(r_fill);
                div_den   = {17'b0, r_fill, 1'b0};
                n_state   = ST_VDIV;
            end
            ST_VDIV: begin
                if (div_done) begin
                    n_state = ST_UPD1;
                end
            end
            ST_UPD1: n_state = ST_UPD2;
            ST_UPD2: begin
                tab_we  = 1'b1;
                n_state = ST_SQI;
            end
            ST_SQI:  n_state = ST_SQ;
            ST_SQ: begin
                if (r_scnt == 5'(SQRT_STEPS - 1)) begin
                    n_state = ST_INV;
                end
            end
            ST_INV: begin
                div_start = 1'b1;
                div_num   = 40'h01_0000_0000 + 40'(r_sres[DIV_DEN_W-1:1]);
                div_den   = r_sres[DIV_DEN_W-1:0];
                n_state   = ST_IDIV;
            end
            ST_IDIV: begin
                if (div_done) begin
                    n_state = ST_ORD;
                end
            end
            ST_ORD: n_state = ST_OM1;
            ST_OM1: n_state = ST_OM2;
            ST_OM2: n_state = ST_OFIN;
            ST_OFIN: begin
                if (out_load) begin
                    n_state = is_last_idx ? ST_IDLE : ST_ORD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign tab_ra = (r_state == ST_IDLE) ? i_cmd.channel : r_ch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sample buffer port
    always_ff @(posedge i_clk) begin
        if (buf_we) begin
            r_buf[r_fill[SPATIAL_W-1:0]] <= i_cmd.sample;
        end
        r_rdata <= r_buf[r_idx];
    end

    // running tables
    always_ff @(posedge i_clk) begin
        if (tab_we) begin
            r_tmean[tab_wa] <= tab_wmean;
            r_tvar[tab_wa]  <= tab_wvar;
        end
        r_tm_rd <= r_tmean[tab_ra];
        r_tv_rd <= r_tvar[tab_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvalid    <= '0;
            r_tvalid_rd <= 1'b0;
        end else begin
            if (tab_we) begin
                r_tvalid[tab_wa] <= 1'b1;
            end
            r_tvalid_rd <= r_tvalid[tab_ra];
        end
    end

    // plane control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_sum  <= '0;
        end else if (buf_we) begin
            r_fill <= r_fill + 1'b1;
            r_sum  <= r_sum + 24'(i_cmd.sample);
        end else if (out_load && is_last_idx) begin
            r_fill <= '0;
            r_sum  <= '0;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_ch    <= i_cmd.channel;
                r_gamma <= i_cmd.scale;
                r_beta  <= i_cmd.shift;
                r_idx   <= '0;
                r_acc   <= '0;
            end
            ST_STAT: begin
                r_old_mean <= old_mean;
                r_old_var  <= old_var;
                r_mean     <= old_mean;
                r_var      <= old_var;
            end
            ST_MDIV: begin
                if (div_done) begin
                    r_mean <= div_quot[15:0];
                end
            end
            ST_VSQ: r_sq <= diff_sq[31:0];
            ST_VACC: begin
                r_acc <= r_acc + 39'(r_sq);
                r_idx <= is_last_idx ? '0 : r_idx + 1'b1;
            end
            ST_VDIV: begin
                if (div_done) begin
                    r_var <= (|div_quot[39:32]) ? 32'hFFFF_FFFF : div_quot[31:0];
                end
            end
            ST_UPD1: begin
                r_p1 <= $signed({1'b0, one_minus_mom}) * r_old_mean;
                r_p2 <= $signed({1'b0, i_cfg.momentum}) * r_mean;
                r_p3 <= one_minus_mom * r_old_var;
                r_p4 <= i_cfg.momentum * r_var;
            end
            ST_SQI: begin
                r_sv   <= {1'b0, ((s_sum == '0) ? 33'd1 : s_sum), 16'b0};
                r_sres <= '0;
                r_sbit <= SQRT_W'(1) << 48;
                r_scnt <= '0;
            end
            ST_SQ: begin
                if (sq_ge) begin
                    r_sv   <= r_sv - sq_try;
                    r_sres <= (r_sres >> 1) + r_sbit;
                end else begin
                    r_sres <= r_sres >> 1;
                end
                r_sbit <= r_sbit >> 2;
                r_scnt <= r_scnt + 1'b1;
            end
            ST_IDIV: begin
                if (div_done) begin
                    r_inv <= div_quot[DIV_DEN_W-1:0];
                    r_idx <= '0;
                end
            end
            ST_OM1: r_gd   <= r_gamma * diff;
            ST_OM2: r_prod <= r_gd * $signed({1'b0, r_inv});
            ST_OFIN: begin
                if (out_load) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_out_value        <= (i_cfg.relu_enable && y_sat < 0) ? 16'sd0 : y_sat;
            o_pre_activation   <= y_sat;
            o_element_index    <= r_idx;
            o_last_of_run      <= is_last_idx;
            o_channel_mean     <= r_mean;
            o_channel_variance <= r_var;
        end
    end

    assign o_valid = r_ovalid;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(MAX_SPATIAL))
        else $error("fill count beyond buffer");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load && is_last_idx |=> r_fill == '0 && r_state == ST_IDLE)
        else $error("plane not released after final result");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_MDIV || r_state == ST_VDIV || r_state == ST_IDIV))
        else $error("divider finished outside a wait state");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_STAT) |-> r_fill != '0)
        else $error("empty plane reached statistics");

endmodule
`default_nettype wire

// ===== rtl/batch_norm_relu_channel.sv =====
// Top level of the batch-normalization forward pass with optional ReLU.
`default_nettype none
// Samples of one channel (Q8.8) are collected until an item marked last; then
// the plane is normalized and one result per stored sample is delivered, in
// order, with the pre-activation value and the mean/variance used. Training
// mode derives batch mean and variance from the buffer and blends them into
// the per-channel running tables by momentum; inference mode reads those
// tables. A load item writes one channel's running statistics and gives no
// result. Up to 64 samples are kept; later ones are dropped, the last mark
// still closes the plane. The front end registers and classifies items and
// pushes them into a four-entry queue, so input keeps flowing while the back
// end works. The back end takes in the samples of a plane, then computes the
// statistics (batch mean and variance in training mode only), square root and
// reciprocal with a one-bit-per-cycle divider and a one-step-per-cycle root,
// and then produces each result in turn through the buffer read, two
// multiplies and the output register, held while the output is stalled.
// Configuration: index 0 training_mode, 1 relu_enable, 2 momentum, 3 epsilon.
module batch_norm_relu_channel (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic                            i_req_type,
    input  wire logic [7:0]                      i_channel,
    input  wire logic signed [15:0]              i_sample_value,
    input  wire logic                            i_last_in_channel,
    input  wire logic signed [15:0]              i_scale,
    input  wire logic signed [15:0]              i_shift,
    input  wire logic signed [15:0]              i_load_mean,
    input  wire logic [31:0]                     i_load_variance,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic signed [15:0]                   o_out_value,
    output logic signed [15:0]                   o_pre_activation,
    output logic [5:0]                           o_element_index,
    output logic                                 o_last_of_run,
    output logic signed [15:0]                   o_channel_mean,
    output logic [31:0]                          o_channel_variance,
    input  wire logic                            i_cfg_we,
    input  wire logic [bnr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [15:0]                     i_cfg_data
);
    import bnr_pkg::*;

    t_cfg r_cfg;
    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic front_push;
    logic queue_full;
    logic queue_empty;
    logic back_pop;

    // configuration registers; to be written only while the block is idle, which the block itself does not enforce
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.training_mode <= 1'b1;
            r_cfg.relu_enable   <= 1'b1;
            r_cfg.momentum      <= MOMENTUM_RST;
            r_cfg.epsilon       <= EPSILON_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TRAINING: r_cfg.training_mode <= i_cfg_data[0];
                CFG_RELU:     r_cfg.relu_enable   <= i_cfg_data[0];
                CFG_MOMENTUM: r_cfg.momentum      <= i_cfg_data;
                CFG_EPSILON:  r_cfg.epsilon       <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // register and classify incoming items
    bnr_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_req_type        (i_req_type),
        .i_channel         (i_channel),
        .i_sample_value    (i_sample_value),
        .i_last_in_channel (i_last_in_channel),
        .i_scale           (i_scale),
        .i_shift           (i_shift),
        .i_load_mean       (i_load_mean),
        .i_load_variance   (i_load_variance),
        .o_push            (front_push),
        .o_cmd             (front_cmd),
        .i_full            (queue_full)
    );

    // decouple the two halves
    bnr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_cmd),
        .o_full  (queue_full),
        .i_pop   (back_pop),
        .o_data  (queue_cmd),
        .o_empty (queue_empty)
    );

    // statistics, normalization and result delivery
    bnr_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (r_cfg),
        .i_cmd              (queue_cmd),
        .i_empty            (queue_empty),
        .o_pop              (back_pop),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_out_value        (o_out_value),
        .o_pre_activation   (o_pre_activation),
        .o_element_index    (o_element_index),
        .o_last_of_run      (o_last_of_run),
        .o_channel_mean     (o_channel_mean),
        .o_channel_variance (o_channel_variance)
    );

endmodule
`default_nettype wire
